[sv/oets_pkg.sv]
// ----------------------------------------------------------------------------
// oets_pkg
// Shared types and constants for the odd-even transposition sort core.
// ----------------------------------------------------------------------------
package oets_pkg;

   localparam int DATA_WIDTH           = 32;
   localparam int MAX_ELEMENTS_DEFAULT = 16;

   // what every cell of the row does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN,
      CELL_EXCHANGE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        phase_odd;   // exchange pairs (1,2),(3,4).. when set, else (0,1),(2,3)..
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT_ODD,
      ST_SORT_EVEN,
      ST_EMIT
   } sort_state_type;

endpackage

[sv/oets_cell.sv]
// ----------------------------------------------------------------------------
// oets_cell
// One slot of the sorting row: holds an element and its valid flag, and
// trades with its neighbours on load, compare-exchange and drain.
// ----------------------------------------------------------------------------
module oets_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  oets_pkg::cell_cmd_type              cmd,
   input  logic signed [oets_pkg::DATA_WIDTH-1:0] left_data,
   input  logic                                left_valid,
   input  logic                                left_swap,
   input  logic signed [oets_pkg::DATA_WIDTH-1:0] right_data,
   input  logic                                right_valid,
   output logic signed [oets_pkg::DATA_WIDTH-1:0] data,
   output logic                                valid,
   output logic                                swap
);
   import oets_pkg::*;

   localparam logic IS_ODD = 1'(CELL_INDEX % 2);

   logic signed [DATA_WIDTH-1:0] data_ff, data_in;
   logic                         valid_ff, valid_in;
   logic                         is_lower;

   // lower member of its pair in the current phase
   assign is_lower = (IS_ODD == cmd.phase_odd);
   assign swap     = valid_ff & right_valid & (data_ff > right_data);

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (cmd.op)
         CELL_SHIFT_UP: begin
            data_in  = left_data;
            valid_in = left_valid;
         end
         CELL_SHIFT_DOWN: begin
            data_in  = right_data;
            valid_in = right_valid;
         end
         CELL_EXCHANGE: begin
            if (is_lower && swap) begin
               data_in = right_data;
            end else if (!is_lower && left_swap) begin
               data_in = left_data;
            end
         end
         default: begin
            data_in  = data_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

[sv/odd_even_transposition_sort_core.sv]
// ----------------------------------------------------------------------------
// odd_even_transposition_sort_core
// Loads a set of signed words, sorts them ascending, streams them back out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one signed 32-bit word per handshake; req_tlast closes the set.
//            Words arriving once the row of MAX_ELEMENTS cells is full are
//            dropped (the word carrying tlast too) and the run is flagged.
//   rsp_*  : the stored words in ascending order, rsp_tlast on the final
//            one, rsp_tuser high on every word of a run that dropped input.
//   Load   : each accepted word shifts into cell 0 and the row moves up behind it.
//   Sort   : rounds of an odd-pair phase then an even-pair phase, repeated
//            until a round makes no exchange.
//   Emit   : one word per cycle straight from cell 0 while rsp_tready is
//            high; the row shifts down behind it.
//   Load and drain are serial. One set at a time: req_tready is low from the
//   tlast word until the final result is taken. Reset empties the row and
//   returns to loading. A stalled receiver simply holds the row; nothing is
//   lost.
// ----------------------------------------------------------------------------
module odd_even_transposition_sort_core #(
   parameter int MAX_ELEMENTS = oets_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // last_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,   // last_out
   output logic        rsp_tuser    // dropped
);
   import oets_pkg::*;

   sort_state_type state_ff, state_in;
   logic           overflow_ff, overflow_in;
   logic           round_swap_ff, round_swap_in;
   cell_cmd_type   cmd;

   logic signed [DATA_WIDTH-1:0] cell_data  [MAX_ELEMENTS];
   logic                         cell_valid [MAX_ELEMENTS];
   logic                         cell_swap  [MAX_ELEMENTS];

   logic req_accept, rsp_accept, row_full, phase_swap;

   assign row_full   = cell_valid[MAX_ELEMENTS-1];
   assign req_accept = req_tvalid & req_tready;
   assign rsp_accept = rsp_tvalid & rsp_tready;

   // the cell row: cell 0 faces both channels, the top cell sees an empty right
   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] l_data, r_data;
      logic                         l_valid, l_swap, r_valid;
      if (i == 0) begin : g_first
         assign l_data  = $signed(req_tdata);
         assign l_valid = 1'b1;
         assign l_swap  = 1'b0;
      end else begin : g_inner
         assign l_data  = cell_data[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_swap  = cell_swap[i-1];
      end
      if (i == MAX_ELEMENTS - 1) begin : g_top
         assign r_data  = '0;
         assign r_valid = 1'b0;
      end else begin : g_below
         assign r_data  = cell_data[i+1];
         assign r_valid = cell_valid[i+1];
      end
      oets_cell #(.CELL_INDEX(i)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_data   (l_data),
         .left_valid  (l_valid),
         .left_swap   (l_swap),
         .right_data  (r_data),
         .right_valid (r_valid),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .swap        (cell_swap[i])
      );
   end

   // any exchange among the pairs active in this phase
   always_comb begin
      phase_swap = 1'b0;
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         if (1'(i % 2) == cmd.phase_odd) begin
            phase_swap = phase_swap | cell_swap[i];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept && req_tlast) begin
               state_in = ST_SORT_ODD;
            end
         end
         ST_SORT_ODD: begin
            state_in = ST_SORT_EVEN;
         end
         ST_SORT_EVEN: begin
            state_in = (round_swap_ff | phase_swap) ? ST_SORT_ODD : ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_accept && rsp_tlast) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs and row command
   always_comb begin
      cmd.op        = CELL_HOLD;
      cmd.phase_odd = 1'b0;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      overflow_in   = overflow_ff;
      round_swap_in = round_swap_ff;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_accept) begin
               if (row_full) begin
                  overflow_in = 1'b1;       // drop the word, flag the run
               end else begin
                  cmd.op = CELL_SHIFT_UP;
               end
            end
         end
         ST_SORT_ODD: begin
            cmd.op        = CELL_EXCHANGE;
            cmd.phase_odd = 1'b1;
            round_swap_in = phase_swap;     // a new round starts here
         end
         ST_SORT_EVEN: begin
            cmd.op        = CELL_EXCHANGE;
            cmd.phase_odd = 1'b0;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.op = CELL_SHIFT_DOWN;
               if (rsp_tlast) begin
                  overflow_in = 1'b0;
               end
            end
         end
         default: begin
            cmd.op = CELL_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         overflow_ff   <= 1'b0;
         round_swap_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         overflow_ff   <= overflow_in;
         round_swap_ff <= round_swap_in;
      end
   end

   // cell 0 is the output register; the final word has nothing behind it
   assign rsp_tdata = cell_data[0];
   assign rsp_tlast = ~cell_valid[1];
   assign rsp_tuser = overflow_ff;

endmodule

[sv/oets_checker.sv]
// ----------------------------------------------------------------------------
// oets_checker
// Port-level checks on the sort core, bound to its top level.
// ----------------------------------------------------------------------------
module oets_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // one set at a time: never loading and emitting together
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while results are pending");

   // closing word stops the input side
   a_close_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input still open after the closing word");

   // final result ends the burst
   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("result offered after the final word");

   // drop flag is the same across a burst, and the burst has no gaps
   a_flag_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && rsp_tuser == $past(rsp_tuser)))
      else $error("drop flag changed inside a burst");

   // stalled word holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind odd_even_transposition_sort_core oets_checker u_oets_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
